[src/dhte_pkg.sv]
// Package for the double-hash table engine.
// Request mode and result status codes, the stream beat widths and the result type.
// No dependencies.
package dhte_pkg;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_LOOKUP = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam int IN_BITS  = 88;
    localparam int OUT_BITS = 56;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot_index;
        logic [31:0] found_payload;
    } t_result;

endpackage

[src/double_hash_table_engine.sv]
// Double-hash table engine: open-addressing table over one slot memory.
// Depends on dhte_pkg (mode and status codes, beat widths, result type).
//
// After reset the block runs a clearing pass over every slot of the slot memory
// and holds s_tready low meanwhile. A request is then taken in one beat and worked on alone:
// home_slot and probe_step are reduced mod TABLE_SLOTS by a shared compare-subtract unit,
// then each probe is a registered read of the single-port slot memory followed by the
// compare and the next-slot add through the same unit. One finished result is held in an
// output register while the next request is taken.
module double_hash_table_engine
    import dhte_pkg::*;
#(
    parameter int TABLE_SLOTS = 256,
    parameter int KEY_BITS    = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // mode[1:0], key[33:2], payload[65:34], home_slot[73:66], probe_step[81:74], zero pad
    input  logic [IN_BITS-1:0]  i_s_tdata,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // status[1:0], slot_index[9:2], found_payload[41:10], occupancy[50:42], zero pad
    output logic [OUT_BITS-1:0] o_m_tdata
);

    localparam int SW   = (TABLE_SLOTS > 2) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CW   = ((SW > 8) ? SW : 8) + 1;
    localparam int KB   = (KEY_BITS < 32) ? KEY_BITS : 32;
    localparam int MW   = 1 + KB + 32;
    localparam int CNTW = $clog2(TABLE_SLOTS + 1);
    localparam logic [CW-1:0]   SLOTS_C = CW'(TABLE_SLOTS);
    localparam logic [CW-1:0]   LAST_C  = CW'(TABLE_SLOTS - 1);
    localparam logic [CNTW-1:0] SLOTS_N = CNTW'(TABLE_SLOTS);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MODH  = 3'd2;
    localparam logic [2:0] S_MODS  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_STEP  = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]      r_state;
    logic [1:0]      r_mode;
    logic [KB-1:0]   r_key;
    logic [31:0]     r_payload;
    logic [CW-1:0]   r_pos;
    logic [CW-1:0]   r_step;
    logic [CW-1:0]   r_home;
    logic [CNTW-1:0] r_count;
    t_result         r_res;
    logic            r_out_valid;
    logic [OUT_BITS-1:0] r_out_data;

    logic [MW-1:0] mem [TABLE_SLOTS];
    logic [MW-1:0] r_rd;

    logic [CW-1:0] u_in;
    logic          u_ge;
    logic [CW-1:0] u_red;
    logic [SW-1:0] rd_addr;
    logic          w_en;
    logic [MW-1:0] w_data;
    logic          rd_valid;
    logic [KB-1:0] rd_key;
    logic [31:0]   rd_pay;
    logic          key_hit;
    logic          out_free;

    assign rd_valid = r_rd[MW-1];
    assign rd_key   = r_rd[MW-2:32];
    assign rd_pay   = r_rd[31:0];
    assign key_hit  = rd_valid && (rd_key == r_key);
    assign out_free = !r_out_valid || i_m_tready;

    // shared add / compare-subtract unit
    always_comb begin
        unique case (r_state)
            S_MODS:  u_in = r_step;
            S_STEP:  u_in = r_pos + r_step;
            default: u_in = r_pos;
        endcase
        u_ge  = (u_in >= SLOTS_C);
        u_red = u_ge ? (u_in - SLOTS_C) : u_in;
    end

    assign rd_addr = (r_state == S_STEP) ? u_red[SW-1:0] : r_pos[SW-1:0];

    always_comb begin
        w_en   = 1'b0;
        w_data = '0;
        if (r_state == S_CLEAR) begin
            w_en = 1'b1;
        end else if (r_state == S_EVAL) begin
            if (r_mode == MODE_INSERT && !rd_valid) begin
                w_en   = 1'b1;
                w_data = {1'b1, r_key, r_payload};
            end else if (r_mode == MODE_REMOVE && key_hit) begin
                w_en   = 1'b1;
                w_data = {1'b0, rd_key, rd_pay};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[r_pos[SW-1:0]] <= w_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_pos       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_pos <= r_pos + 1'b1;
                    if (r_pos == LAST_C) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_mode    <= i_s_tdata[1:0];
                        r_key     <= i_s_tdata[2 +: KB];
                        r_payload <= i_s_tdata[65:34];
                        r_pos     <= CW'(i_s_tdata[73:66]);
                        r_step    <= CW'(i_s_tdata[81:74]);
                        r_state   <= S_MODH;
                    end
                end
                S_MODH: begin
                    r_pos <= u_red;
                    if (!u_ge) begin
                        r_state <= S_MODS;
                    end
                end
                S_MODS: begin
                    r_step <= u_red;
                    if (!u_ge) begin
                        r_home  <= r_pos;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    unique case (r_mode)
                        MODE_INSERT: begin
                            if (!rd_valid) begin
                                r_res   <= '{status: ST_OK, slot_index: 8'(r_pos),
                                             found_payload: '0};
                                r_count <= r_count + 1'b1;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_STEP;
                            end
                        end
                        MODE_REMOVE: begin
                            if (key_hit) begin
                                r_res   <= '{status: ST_OK, slot_index: 8'(r_pos),
                                             found_payload: '0};
                                if (r_count != '0) begin
                                    r_count <= r_count - 1'b1;
                                end
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_STEP;
                            end
                        end
                        MODE_LOOKUP: begin
                            if (key_hit) begin
                                r_res   <= '{status: ST_OK, slot_index: 8'(r_pos),
                                             found_payload: rd_pay};
                                r_state <= S_DONE;
                            end else if (rd_valid) begin
                                r_state <= S_STEP;
                            end else begin
                                r_res   <= '{status: ST_MISS, slot_index: '0,
                                             found_payload: '0};
                                r_state <= S_DONE;
                            end
                        end
                        default: begin
                            r_res   <= '{status: ST_MISS, slot_index: '0, found_payload: '0};
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_STEP: begin
                    r_pos <= u_red;
                    if (u_red == r_home) begin
                        r_res.status        <= (r_mode == MODE_INSERT) ? ST_FULL : ST_MISS;
                        r_res.slot_index    <= '0;
                        r_res.found_payload <= '0;
                        r_state             <= S_DONE;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_data  <= OUT_BITS'({9'(r_count), r_res.found_payload,
                                                  r_res.slot_index, r_res.status});
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_N)
        else $error("occupancy above table size");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> (r_pos < SLOTS_C) && (r_step < SLOTS_C))
        else $error("probe slot or step not reduced");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL && r_mode == MODE_INSERT && !rd_valid)
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise occupancy");

    a_result_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> r_out_valid && (r_state == S_IDLE))
        else $error("finished request not issued");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_MODH))
        else $error("accepted beat did not start a request");

endmodule

[tb/dhte_checker.sv]
// Checker for the double-hash table engine: watches both stream channels, keeps its own
// copy of the slot table, predicts each result beat and compares it field by field.
// Depends on dhte_pkg (mode and status codes, beat widths).
module dhte_checker
    import dhte_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [IN_BITS-1:0]  i_s_tdata,
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [OUT_BITS-1:0] i_m_tdata,
    output int                  o_pending,
    output int                  o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS      = 256;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  slot_index;
        logic [31:0] found_payload;
        logic [8:0]  occupancy;
    } t_outcome;

    logic        table_valid [SLOTS];
    logic [31:0] table_key   [SLOTS];
    logic [31:0] table_data  [SLOTS];
    logic [8:0]  table_fill;

    t_outcome    expected_results [$];
    int          result_beats;
    int          fail_count;

    // Walk the probe chain; true with the stopping slot in hit
    function automatic bit walk_chain(input logic [1:0] mode, input logic [31:0] key,
                                      input logic [7:0] home, input logic [7:0] step,
                                      output logic [7:0] hit);
        logic [7:0] pos;
        int         n;
        pos = home;
        hit = '0;
        for (n = 0; n < SLOTS; n++) begin
            if (mode == MODE_INSERT) begin
                if (!table_valid[pos]) begin
                    hit = pos;
                    return 1'b1;
                end
            end else begin
                if (table_valid[pos] && table_key[pos] == key) begin
                    hit = pos;
                    return 1'b1;
                end
                if (!table_valid[pos] && mode == MODE_LOOKUP)
                    return 1'b0;
            end
            pos = pos + step;
            if (pos == home)
                return 1'b0;
        end
        return 1'b0;
    endfunction

    function automatic t_outcome predict_request(input logic [IN_BITS-1:0] beat);
        logic [1:0]  mode;
        logic [31:0] key;
        logic [31:0] payload;
        logic [7:0]  home;
        logic [7:0]  step;
        logic [7:0]  hit;
        t_outcome    res;
        mode    = beat[1:0];
        key     = beat[33:2];
        payload = beat[65:34];
        home    = beat[73:66];
        step    = beat[81:74];
        res     = '{status: ST_MISS, slot_index: '0, found_payload: '0, occupancy: '0};
        case (mode)
            MODE_INSERT: begin
                if (walk_chain(mode, key, home, step, hit)) begin
                    table_valid[hit] = 1'b1;
                    table_key[hit]   = key;
                    table_data[hit]  = payload;
                    table_fill       = table_fill + 1'b1;
                    res.status       = ST_OK;
                    res.slot_index   = hit;
                end else begin
                    res.status = ST_FULL;
                end
            end
            MODE_REMOVE: begin
                if (walk_chain(mode, key, home, step, hit)) begin
                    table_valid[hit] = 1'b0;
                    if (table_fill != 0)
                        table_fill = table_fill - 1'b1;
                    res.status     = ST_OK;
                    res.slot_index = hit;
                end
            end
            MODE_LOOKUP: begin
                if (walk_chain(mode, key, home, step, hit)) begin
                    res.status        = ST_OK;
                    res.slot_index    = hit;
                    res.found_payload = table_data[hit];
                end
            end
            default: ;
        endcase
        res.occupancy = table_fill;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch: result beat %0d %s got 0x%0h expected 0x%0h",
                 result_beats, field, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                table_valid[i] = 1'b0;
                table_key[i]   = '0;
                table_data[i]  = '0;
            end
            table_fill = '0;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected beat", i_m_tdata[31:0], '0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_m_tdata[1:0] !== want.status)
                        report_mismatch("status", i_m_tdata[1:0], want.status);
                    if (i_m_tdata[9:2] !== want.slot_index)
                        report_mismatch("slot_index", i_m_tdata[9:2], want.slot_index);
                    if (i_m_tdata[41:10] !== want.found_payload)
                        report_mismatch("found_payload", i_m_tdata[41:10], want.found_payload);
                    if (i_m_tdata[50:42] !== want.occupancy)
                        report_mismatch("occupancy", i_m_tdata[50:42], want.occupancy);
                end
                result_beats++;
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(predict_request(i_s_tdata));
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fail_count;
    end

    initial begin
        result_beats = 0;
        fail_count   = 0;
        o_pending    = 0;
        o_fail_count = 0;
        table_fill   = '0;
    end

endmodule

[tb/tb_top.sv]
// Testbench top for the double-hash table engine: clock, reset, request stimulus and
// result-side back-pressure, watchdog and verdict.
// Depends on dhte_pkg, double_hash_table_engine and dhte_checker.
module tb_top
    import dhte_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int POOL        = 48;
    localparam int IDLE_LIMIT  = 5000;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_BITS-1:0]  s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_BITS-1:0] m_tdata;

    int                  pending;
    int                  fail_count;
    int                  idle_cycles;
    int                  rx_hold;
    int                  rx_roll;
    bit                  tx_gaps_on;
    bit                  rx_stalls_on;

    logic [31:0]         pool_key  [POOL];
    logic [7:0]          pool_home [POOL];
    logic [7:0]          pool_step [POOL];

    double_hash_table_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    dhte_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // result-side back-pressure
    always @(negedge i_clk) begin
        if (!rx_stalls_on) begin
            m_tready <= 1'b1;
        end else if (rx_hold > 0) begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end else begin
            rx_roll = $urandom_range(0, 99);
            if (rx_roll < 60) begin
                m_tready <= 1'b1;
            end else if (rx_roll < 92) begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(0, 2);
            end else begin
                m_tready <= 1'b0;
                rx_hold  <= $urandom_range(8, 40);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!tx_gaps_on || roll < 65)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_request(input logic [1:0] mode, input logic [31:0] key,
                                input logic [31:0] payload, input logic [7:0] home,
                                input logic [7:0] step);
        int gap;
        gap = pick_gap();
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, step, home, payload, key, mode};
        do @(posedge i_clk); while (!s_tready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic issue_random(input int ins_pct, input int rem_pct, input int fresh_pct);
        int          roll;
        int          idx;
        logic [1:0]  mode;
        logic [31:0] key;
        logic [7:0]  home;
        logic [7:0]  step;
        idx  = $urandom_range(0, POOL - 1);
        roll = $urandom_range(0, 99);
        mode = (roll < ins_pct) ? MODE_INSERT :
               (roll < ins_pct + rem_pct) ? MODE_REMOVE : MODE_LOOKUP;
        key  = pool_key[idx];
        home = pool_home[idx];
        step = pool_step[idx];
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            // noise: any mode, unrelated hashes
            mode = 2'($urandom_range(0, 3));
            key  = $urandom;
            home = 8'($urandom_range(0, 255));
            step = 8'($urandom_range(0, 255));
        end else if (roll < 4 + fresh_pct) begin
            key  = $urandom;
            home = 8'($urandom_range(0, 255));
            step = 8'($urandom_range(0, 127) * 2 + 1);
        end
        send_request(mode, key, $urandom, home, step);
    endtask

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        rx_hold      = 0;
        idle_cycles  = 0;
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;

        for (int i = 0; i < POOL; i++) begin
            pool_key[i]  = $urandom;
            pool_home[i] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 70)
                pool_step[i] = 8'($urandom_range(0, 127) * 2 + 1);
            else
                pool_step[i] = 8'($urandom_range(1, 127) * 2);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty table: lookup stops at once, remove walks the whole ring
        send_request(MODE_LOOKUP, 32'h0000_0000, 32'h0, 8'd0, 8'd1);
        send_request(MODE_REMOVE, 32'h0000_0000, 32'h0, 8'd0, 8'd1);
        send_request(MODE_INSERT, 32'h0000_0000, 32'h0000_0000, 8'd0, 8'd1);
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255);
        // duplicate key lands one step further on
        send_request(MODE_INSERT, 32'hFFFF_FFFF, 32'h1234_5678, 8'd255, 8'd255);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'd255, 8'd255);
        send_request(MODE_LOOKUP, 32'h0000_0000, 32'h0, 8'd0, 8'd1);
        // zero step only sees the home slot
        send_request(MODE_INSERT, 32'h0000_00A5, 32'hCAFE_0001, 8'd7, 8'd0);
        send_request(MODE_INSERT, 32'h0000_00A6, 32'hCAFE_0002, 8'd7, 8'd0);
        send_request(MODE_LOOKUP, 32'h0000_00A6, 32'h0, 8'd7, 8'd0);
        // step of half the table: a two-slot ring
        send_request(MODE_INSERT, 32'h0000_0100, 32'hBEEF_0000, 8'd9, 8'd128);
        send_request(MODE_INSERT, 32'h0000_0101, 32'hBEEF_0001, 8'd9, 8'd128);
        send_request(MODE_INSERT, 32'h0000_0102, 32'hBEEF_0002, 8'd9, 8'd128);
        send_request(MODE_REMOVE, 32'h0000_0100, 32'h0, 8'd9, 8'd128);
        // no tombstone: lookup stops at the hole, remove passes over it
        send_request(MODE_LOOKUP, 32'h0000_0101, 32'h0, 8'd9, 8'd128);
        send_request(MODE_REMOVE, 32'h0000_0101, 32'h0, 8'd9, 8'd128);
        send_request(MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 8'd255);
        send_request(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 8'd255, 8'd255);
        send_request(MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0, 8'd255, 8'd255);
        send_request(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 8'd255, 8'd255);
        send_request(MODE_LOOKUP, 32'h5A5A_5A5A, 32'h0, 8'd128, 8'd2);
        send_request(MODE_INSERT, 32'hDEAD_BEEF, 32'h0000_0000, 8'd0, 8'd1);
        send_request(MODE_LOOKUP, 32'hDEAD_BEEF, 32'h0, 8'd0, 8'd1);
        drain_results();

        // mixed traffic at growing load
        for (int i = 0; i < 250; i++)
            issue_random(55, 15, 10);

        // back-to-back stretch, sink always ready
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        for (int i = 0; i < 100; i++)
            issue_random(50, 20, 10);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        drain_results();

        // fill past capacity so inserts report full
        for (int i = 0; i < 200; i++)
            issue_random(95, 0, 85);

        // mostly removes: thin the table out
        for (int i = 0; i < 100; i++)
            issue_random(10, 60, 5);

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
src/dhte_pkg.sv
src/double_hash_table_engine.sv
tb/dhte_checker.sv
tb/tb_top.sv
